// ===== design/gcd_pkg.sv =====
// Shared constants, tables and types of the great-circle distance pipeline.
// No dependencies; gcd_front, gcd_sincos, gcd_back and the top level import this package.
package gcd_pkg;

    localparam int ANGLE_FRAC_BITS = 23;
    localparam int DIST_FRAC_BITS  = 4;

    localparam int LAT_W    = 31;
    localparam int LON_W    = 32;
    localparam int DIST_W   = 30;
    localparam int RADIUS_W = 24;
    localparam int TURN_W   = 32;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;

    localparam int QUEUE_DEPTH_LOG2_DEF = 2;

    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;
    localparam int SQRT_STEPS   = 31;
    localparam int SQRT_W       = 62;

    // Back pipeline: fold + 30 rotation steps, three product stages,
    // 31 root steps, 30 vectoring steps, two scaling multiplies.
    localparam int PIPE_LAT = 1 + CORDIC_STEPS + 3 + SQRT_STEPS + CORDIC_STEPS + 2;

    localparam logic [29:0] DEG_TO_TURN = 30'd763549742;
    localparam logic signed [CORDIC_W-1:0] INV_GAIN = 34'sd652032874;
    localparam logic [30:0] PI_Q29  = 31'd1686629713;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
    };

    // Four angles in binary turns, handed from the front to the back.
    typedef struct packed {
        logic [TURN_W-1:0] lat_half;
        logic [TURN_W-1:0] lon_half;
        logic [TURN_W-1:0] lat1;
        logic [TURN_W-1:0] lat2;
    } gcd_angles_t;

endpackage

// ===== design/gcd_fifo.sv =====
// Small synchronous queue built from registers, used between pipeline parts.
// No package dependencies.
module gcd_fifo #(
    parameter int WIDTH      = 8,
    parameter int DEPTH_LOG2 = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int DEPTH = 2 ** DEPTH_LOG2;

    logic [WIDTH-1:0]      mem_reg [DEPTH];
    logic [DEPTH_LOG2-1:0] wr_ptr_reg;
    logic [DEPTH_LOG2-1:0] rd_ptr_reg;
    logic [DEPTH_LOG2:0]   count_reg;
    logic [DEPTH_LOG2:0]   count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (count_reg == (DEPTH_LOG2+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== design/gcd_front.sv =====
// Front part: accepts point pairs, forms the differences and converts all
// four angles to binary turns. Depends on gcd_pkg.
module gcd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic signed [30:0]         first_latitude,
    input  logic signed [31:0]         first_longitude,
    input  logic signed [30:0]         second_latitude,
    input  logic signed [31:0]         second_longitude,
    input  logic                       mq_full,
    output logic                       mq_push,
    output gcd_pkg::gcd_angles_t       mq_data
);
    import gcd_pkg::*;

    // Degrees to turns with rounding; the half-angle form shifts one further.
    function automatic logic [TURN_W-1:0] to_turns(logic signed [32:0] v, logic half);
        logic [63:0] p;
        begin
            p = 64'(v) * 64'(DEG_TO_TURN);
            if (half)
            begin
                p = p + (64'(1) << (ANGLE_FRAC_BITS + 6));
                to_turns = TURN_W'(p >> (ANGLE_FRAC_BITS + 7));
            end
            else
            begin
                p = p + (64'(1) << (ANGLE_FRAC_BITS + 5));
                to_turns = TURN_W'(p >> (ANGLE_FRAC_BITS + 6));
            end
        end
    endfunction

    logic              en;
    logic              f1_vld_reg;
    logic              f2_vld_reg;
    logic signed [32:0] dlat_reg;
    logic signed [32:0] dlon_reg;
    logic signed [32:0] lat1_reg;
    logic signed [32:0] lat2_reg;
    gcd_angles_t       angles_reg;

    assign en      = !mq_full;
    assign full    = mq_full;
    assign mq_push = en && f2_vld_reg;
    assign mq_data = angles_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_vld_reg <= push;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dlat_reg <= 33'(second_latitude) - 33'(first_latitude);
            dlon_reg <= 33'(second_longitude) - 33'(first_longitude);
            lat1_reg <= 33'(first_latitude);
            lat2_reg <= 33'(second_latitude);
            angles_reg.lat_half <= to_turns(dlat_reg, 1'b1);
            angles_reg.lon_half <= to_turns(dlon_reg, 1'b1);
            angles_reg.lat1     <= to_turns(lat1_reg, 1'b0);
            angles_reg.lat2     <= to_turns(lat2_reg, 1'b0);
        end
    end

endmodule

// ===== design/gcd_sincos.sv =====
// Pipelined CORDIC rotation giving sine and cosine of an angle in turns.
// Depends on gcd_pkg for the arctangent table and widths.
module gcd_sincos (
    input  logic                 clk,
    input  logic                 en,
    input  logic [31:0]          angle,
    output logic signed [31:0]   sin_val,
    output logic signed [31:0]   cos_val
);
    import gcd_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] z_reg [CORDIC_STEPS+1];
    logic                       flip_reg [CORDIC_STEPS+1];
    logic                       flip_in;
    logic [31:0]                folded;
    logic signed [CORDIC_W-1:0] x_out;
    logic signed [CORDIC_W-1:0] y_out;

    // Angles in the left half plane are turned by half a turn and negated after.
    assign flip_in = (angle - 32'h4000_0000) < 32'h8000_0000;
    assign folded  = flip_in ? angle + 32'h8000_0000 : angle;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= INV_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= {{(CORDIC_W-32){folded[31]}}, folded};
            flip_reg[0] <= flip_in;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][CORDIC_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed(CORDIC_W'(ATAN_TURNS[i]));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed(CORDIC_W'(ATAN_TURNS[i]));
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    assign x_out   = flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
    assign y_out   = flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
    assign sin_val = y_out[31:0];
    assign cos_val = x_out[31:0];

endmodule

// ===== design/gcd_back.sv =====
// Back part: sine and cosine, haversine term, square roots, vectoring CORDIC
// and scaling by the radius, all as one stall-together pipeline. Depends on gcd_pkg.
module gcd_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       mq_empty,
    input  gcd_pkg::gcd_angles_t       mq_data,
    output logic                       mq_pop,
    input  logic [23:0]                radius,
    input  logic                       oq_full,
    output logic                       oq_push,
    output logic [29:0]                oq_data
);
    import gcd_pkg::*;

    logic en;
    logic vld_reg [PIPE_LAT];

    assign en      = !oq_full;
    assign mq_pop  = en && !mq_empty;
    assign oq_push = en && vld_reg[PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= !mq_empty;
            for (int k = 1; k < PIPE_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Sine and cosine lanes.
    logic signed [31:0] sd;
    logic signed [31:0] sl;
    logic signed [31:0] c1;
    logic signed [31:0] c2;

    gcd_sincos u_sc_dlat (.clk(clk), .en(en), .angle(mq_data.lat_half),
                          .sin_val(sd), .cos_val());
    gcd_sincos u_sc_dlon (.clk(clk), .en(en), .angle(mq_data.lon_half),
                          .sin_val(sl), .cos_val());
    gcd_sincos u_sc_lat1 (.clk(clk), .en(en), .angle(mq_data.lat1),
                          .sin_val(), .cos_val(c1));
    gcd_sincos u_sc_lat2 (.clk(clk), .en(en), .angle(mq_data.lat2),
                          .sin_val(), .cos_val(c2));

    // Haversine term in three product stages.
    logic signed [63:0] pd;
    logic signed [63:0] pl;
    logic signed [63:0] pc;
    logic signed [63:0] pt;
    logic signed [31:0] sqd_reg;
    logic signed [31:0] sql_reg;
    logic signed [31:0] cc_reg;
    logic signed [31:0] sqd2_reg;
    logic signed [31:0] t_reg;
    logic signed [32:0] a_sum;
    logic [30:0]        a_clamped;
    logic [30:0]        a_reg;

    assign pd = 64'(sd) * 64'(sd);
    assign pl = 64'(sl) * 64'(sl);
    assign pc = 64'(c1) * 64'(c2);
    assign pt = 64'(cc_reg) * 64'(sql_reg);
    assign a_sum = 33'(sqd2_reg) + 33'(t_reg);

    always_comb
    begin
        priority if (a_sum[32])
        begin
            a_clamped = '0;
        end
        else if (a_sum > 33'(ONE_Q30))
        begin
            a_clamped = ONE_Q30;
        end
        else
        begin
            a_clamped = a_sum[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqd_reg  <= pd[61:30];
            sql_reg  <= pl[61:30];
            cc_reg   <= pc[61:30];
            sqd2_reg <= sqd_reg;
            t_reg    <= pt[61:30];
            a_reg    <= a_clamped;
        end
    end

    // Two bit-pair square root pipelines: lane 0 for sqrt(a), lane 1 for sqrt(1-a).
    logic [SQRT_W-1:0] sq_n_reg [2][SQRT_STEPS];
    logic [SQRT_W-1:0] sq_r_reg [2][SQRT_STEPS];
    logic [SQRT_W-1:0] sq_n_in  [2][SQRT_STEPS];
    logic [SQRT_W-1:0] sq_r_in  [2][SQRT_STEPS];

    for (genvar ln = 0; ln < 2; ln++)
    begin : g_lane
        for (genvar k = 0; k < SQRT_STEPS; k++)
        begin : g_sq
            localparam logic [SQRT_W-1:0] BIT_K = SQRT_W'(1) << (60 - 2 * k);
            if (k == 0)
            begin : g_first
                if (ln == 0)
                begin : g_y
                    assign sq_n_in[ln][k] = SQRT_W'(a_reg) << 30;
                end
                else
                begin : g_x
                    assign sq_n_in[ln][k] = SQRT_W'(ONE_Q30 - a_reg) << 30;
                end
                assign sq_r_in[ln][k] = '0;
            end
            else
            begin : g_rest
                assign sq_n_in[ln][k] = sq_n_reg[ln][k-1];
                assign sq_r_in[ln][k] = sq_r_reg[ln][k-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (sq_n_in[ln][k] >= sq_r_in[ln][k] + BIT_K)
                    begin
                        sq_n_reg[ln][k] <= sq_n_in[ln][k] - (sq_r_in[ln][k] + BIT_K);
                        sq_r_reg[ln][k] <= (sq_r_in[ln][k] >> 1) + BIT_K;
                    end
                    else
                    begin
                        sq_n_reg[ln][k] <= sq_n_in[ln][k];
                        sq_r_reg[ln][k] <= sq_r_in[ln][k] >> 1;
                    end
                end
            end
        end
    end

    // Vectoring CORDIC for the central angle.
    logic signed [CORDIC_W-1:0] vx_reg [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] vy_reg [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] vz_reg [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] vx_in  [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] vy_in  [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] vz_in  [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        if (i == 0)
        begin : g_first
            assign vx_in[i] = $signed(CORDIC_W'(sq_r_reg[1][SQRT_STEPS-1][30:0]));
            assign vy_in[i] = $signed(CORDIC_W'(sq_r_reg[0][SQRT_STEPS-1][30:0]));
            assign vz_in[i] = '0;
        end
        else
        begin : g_rest
            assign vx_in[i] = vx_reg[i-1];
            assign vy_in[i] = vy_reg[i-1];
            assign vz_in[i] = vz_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!vy_in[i][CORDIC_W-1] && (vy_in[i] != '0))
                begin
                    vx_reg[i] <= vx_in[i] + (vy_in[i] >>> i);
                    vy_reg[i] <= vy_in[i] - (vx_in[i] >>> i);
                    vz_reg[i] <= vz_in[i] + $signed(CORDIC_W'(ATAN_TURNS[i]));
                end
                else
                begin
                    vx_reg[i] <= vx_in[i] - (vy_in[i] >>> i);
                    vy_reg[i] <= vy_in[i] + (vx_in[i] >>> i);
                    vz_reg[i] <= vz_in[i] - $signed(CORDIC_W'(ATAN_TURNS[i]));
                end
            end
        end
    end

    // Angle to radians, then times the radius, with rounding and saturation.
    logic signed [CORDIC_W-1:0] z_fin;
    logic [30:0]                z_clamped;
    logic [61:0]                pu;
    logic [34:0]                u_reg;
    logic [59:0]                prod_reg;
    logic [59:0]                d_round;
    logic [59:0]                d_full;

    assign z_fin = vz_reg[CORDIC_STEPS-1];

    always_comb
    begin
        priority if (z_fin[CORDIC_W-1])
        begin
            z_clamped = '0;
        end
        else if (z_fin > $signed(CORDIC_W'(ONE_Q30)))
        begin
            z_clamped = ONE_Q30;
        end
        else
        begin
            z_clamped = z_fin[30:0];
        end
    end

    assign pu      = 62'(z_clamped) * 62'(PI_Q29);
    assign d_round = prod_reg + (60'(1) << (31 - DIST_FRAC_BITS));
    assign d_full  = d_round >> (32 - DIST_FRAC_BITS);
    assign oq_data = (d_full > 60'h3FFF_FFFF) ? 30'h3FFF_FFFF : d_full[29:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= pu[61:27];
            prod_reg <= 60'(radius) * 60'(u_reg);
        end
    end

endmodule

// ===== design/great_circle_distance_top.sv =====
// Top level of the great-circle distance block: front part, angle queue,
// back pipeline and result queue. Depends on gcd_pkg, gcd_fifo, gcd_front, gcd_back.
//
//   channel  | signals                                     | transfer when
//   ---------+---------------------------------------------+-------------------
//   input    | push, full, first/second latitude/longitude | push && !full
//   result   | empty, pop, distance                        | pop && !empty
//   config   | cfg_valid, cfg_ready, cfg_data (radius)     | cfg_valid && cfg_ready
//
// One point pair is accepted per cycle while full is low; the path from a transfer
// to its result runs through the 30-step rotation CORDIC, the 31-step square root
// and the 30-step vectoring CORDIC pipelines.
// Reset clears the queues and valid bits and loads a radius of 6371000 m.
// A full result queue halts the back pipeline; the angle queue then fills
// and raises full. The radius register is always ready.
module great_circle_distance_top #(
    parameter int QUEUE_DEPTH_LOG2 = gcd_pkg::QUEUE_DEPTH_LOG2_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [30:0]  first_latitude,
    input  logic signed [31:0]  first_longitude,
    input  logic signed [30:0]  second_latitude,
    input  logic signed [31:0]  second_longitude,
    output logic                empty,
    input  logic                pop,
    output logic [29:0]         distance,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [23:0]         cfg_data
);
    import gcd_pkg::*;

    logic [RADIUS_W-1:0] radius_reg;
    logic                mq_full;
    logic                mq_push;
    gcd_angles_t         mq_wdata;
    gcd_angles_t         mq_rdata;
    logic                mq_pop;
    logic                mq_empty;
    logic                oq_full;
    logic                oq_push;
    logic [DIST_W-1:0]   oq_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radius_reg <= cfg_data;
        end
    end

    gcd_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .first_latitude   (first_latitude),
        .first_longitude  (first_longitude),
        .second_latitude  (second_latitude),
        .second_longitude (second_longitude),
        .mq_full          (mq_full),
        .mq_push          (mq_push),
        .mq_data          (mq_wdata)
    );

    gcd_fifo #(
        .WIDTH      ($bits(gcd_angles_t)),
        .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
    ) u_angle_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mq_push),
        .wdata (mq_wdata),
        .full  (mq_full),
        .pop   (mq_pop),
        .rdata (mq_rdata),
        .empty (mq_empty)
    );

    gcd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .mq_empty (mq_empty),
        .mq_data  (mq_rdata),
        .mq_pop   (mq_pop),
        .radius   (radius_reg),
        .oq_full  (oq_full),
        .oq_push  (oq_push),
        .oq_data  (oq_data)
    );

    gcd_fifo #(
        .WIDTH      (DIST_W),
        .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .wdata (oq_data),
        .full  (oq_full),
        .pop   (pop),
        .rdata (distance),
        .empty (empty)
    );

endmodule

// ===== design/gcd_checker.sv =====
// Port-level checker for the great-circle distance block, bound to the top level.
// Depends only on the top level's ports and its queue depth parameter.
module gcd_port_props #(
    parameter int QUEUE_DEPTH_LOG2 = 2
) (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [29:0] distance
);

    logic [15:0] pend_reg;
    logic [15:0] pend_next;
    logic        acc_in;
    logic        acc_out;

    assign acc_in  = push && !full;
    assign acc_out = pop && !empty;

    always_comb
    begin
        pend_next = pend_reg;
        if (acc_in && !acc_out)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (acc_out && !acc_in)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> empty)
        else $error("result queue not empty after reset");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(distance)))
        else $error("waiting result changed or vanished");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pend_reg != 16'd0))
        else $error("result shown with no item outstanding");

    a_full_backed: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (pend_reg >= 16'(2 ** QUEUE_DEPTH_LOG2)))
        else $error("full raised with too few items outstanding");

endmodule

bind great_circle_distance_top gcd_port_props #(
    .QUEUE_DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
) u_gcd_port_props (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .distance (distance)
);
